[rtl/core/chained_string_hash_table_top_macros.svh]
// Assertion macros shared by the hash table RTL.
`ifndef CHAINED_STRING_HASH_TABLE_TOP_MACROS_SVH
`define CHAINED_STRING_HASH_TABLE_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash table assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CSHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash table assertion failed");

`endif

[rtl/core/csht_pkg.sv]
package csht_pkg;

    // Default sizes of the table.
    localparam int BUCKETS_DEF      = 1024;
    localparam int ENTRIES_DEF      = 1024;
    localparam int KEY_BYTES_DEF    = 32;
    localparam int PAYLOAD_BITS     = 32;
    localparam int MASK_W           = 10;
    localparam int INDEX_W          = 10;
    localparam int COUNT_W          = 11;
    localparam logic [MASK_W-1:0] MASK_RESET = 10'd1023;

    // Operation codes carried on the last key byte.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FOUND     = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    // Running key hash and overflow flag after the current byte.
    typedef struct packed {
        logic [31:0] hash;
        logic        ovf;
    } t_key_info;

    // Mixing table added to the hash for every byte after the first.
    localparam logic [31:0] MIX_TABLE [256] = '{
        32'h4BEF74B7,32'h7FE1F5A6,32'hB4C08BF6,32'hC2CF0CD0,32'h788E2A29,32'hB043B6B9,
        32'h5B56C90C,32'h324D8FE7,32'h8D9C854A,32'hCAE06AC8,32'h902076A1,32'h949EAA31,
        32'hDC070A08,32'hF7499B6D,32'h17883EAA,32'h22A65A35,32'h34FC6407,32'h8322F367,
        32'hD105BB0F,32'hD8A29526,32'h8A1B708A,32'hBE85B1E1,32'hC66AC334,32'hC1B13A1C,
        32'hEDF644E4,32'h3EA3806C,32'h2732D31D,32'hEBF504A9,32'h08BB2B52,32'h4775992C,
        32'h3C0B8CF7,32'h5FA0AEA2,32'h7616D761,32'h66AA86DB,32'hC73305C0,32'h09E6EA99,
        32'hC9789DD6,32'hF47340F1,32'h3941303E,32'h7542233A,32'hE0812ED1,32'hFF2E54FE,
        32'h07B887EB,32'h68CD0E93,32'hB124C17F,32'hD01A9C5B,32'h96B490ED,32'hA7CAE5FC,
        32'h18D41F37,32'h6E8DA1BC,32'h9B631940,32'h35ABCFD4,32'hACA1FB0A,32'h2F71B921,
        32'h6F10A747,32'hA6680796,32'h01F12271,32'hFDBE0378,32'h02F0FF79,32'hEC3FF2D2,
        32'h84485C9C,32'h60BF9113,32'h98CC35E3,32'hAA2A8D4D,32'hA5CBA2E9,32'hF0AE1EF2,
        32'h990118E2,32'h64A966F5,32'h8595490D,32'h7E9B4391,32'hE8311B7D,32'h2474BCBF,
        32'h19D6E286,32'hDFD32D5C,32'hAB5116CA,32'h7D72D6D5,32'h0BF44F5E,32'h6170B3D3,
        32'h2C471CC2,32'h2EFD1118,32'h8C878836,32'h62FE52E0,32'h2B8C1277,32'h2ACEBDEC,
        32'hB2E8A8A3,32'h30B757AE,32'h708BBA8D,32'h501EF654,32'h49A7EF1E,32'hFE7636AD,
        32'hB54BBE4F,32'h1ADBDB8C,32'h72E24DD9,32'hF68A2517,32'hF56FEEDF,32'h5A7EB75D,
        32'hD606F9E6,32'hC32526B8,32'h5EB613F3,32'h0C08CBDE,32'h8B965E59,32'hB361EB75,
        32'h3FADE465,32'hB8FFD16F,32'h26442988,32'h00D2D830,32'h3D58FE41,32'h3B386E44,
        32'h1297E914,32'hAFC11083,32'hC5EBE8B6,32'h15A49ECD,32'hF950C263,32'hA0DA0982,
        32'h4CBDF101,32'hE227F77E,32'h556DB8DA,32'hA1BA2125,32'h1E3BD409,32'hFCF25155,
        32'h110A983B,32'h7B7F1A4C,32'hE7FB4C69,32'hC8994E1F,32'h586C4A42,32'h5C1FAF2F,
        32'hAD777D48,32'h9186696B,32'hD52181B4,32'hE94C39EF,32'h9EDEB2FF,32'h802FDA20,
        32'hA228D902,32'h52BC7CFD,32'h53DD47AC,32'h6D12D25F,32'hCE1D6D8F,32'hF12C8E2B,
        32'hDD5700C1,32'h9A402851,32'h386E53D7,32'h0DF88281,32'h4A55CDC4,32'h653692B0,
        32'h203CAC8E,32'h747C6164,32'hC47A02B2,32'h1B4FC82D,32'hF8934B7A,32'h36A82CB5,
        32'h690CD080,32'h2800A524,32'h1C045D0E,32'hBF09CAF0,32'h8814ABB3,32'hE3D0776A,
        32'h219AA6D8,32'hCC375653,32'hFA2327A8,32'h57F75F27,32'h732DA903,32'h8F696738,
        32'h3A453223,32'hDA1C9F32,32'hCF90152A,32'h0F64BFF4,32'hD7533FA5,32'h8E7D55DC,
        32'hBC598998,32'h45110DBA,32'h4D92E6FB,32'h7746C01A,32'h951348A0,32'hBBFA7E9B,
        32'h055EAD7B,32'h06B36BBB,32'h0EE31D97,32'h37297F11,32'hEF529450,32'h51C6E168,
        32'h1F67C63F,32'h6B023443,32'h449F5BFA,32'h48C39A4B,32'hD30E426E,32'h0ADFE31B,
        32'h467B6085,32'h7CC49676,32'h140DFA60,32'hE16B7274,32'h235AEC05,32'hD2D7DCC6,
        32'h13946212,32'h339D2462,32'hFB82F8EE,32'hB6197970,32'hBD0F3C9D,32'hE64E3B28,
        32'hE4B07A87,32'h54C92F95,32'h6CC583AB,32'hD4182015,32'h86DC755A,32'hA930A333,
        32'h82B273EA,32'h923EED7C,32'hF354A02E,32'hEEEEA439,32'h1D89089A,32'hD9EDDEE8,
        32'h1017B504,32'hA45CB0C7,32'h93C7E0A4,32'h43D95858,32'hDB654594,32'h31D578CF,
        32'hCDF98489,32'hB915C7F9,32'h67846FE5,32'h04D150AF,32'h5DF314DD,32'hCB911772,
        32'hA8627156,32'h258FC573,32'hEAA5E79F,32'h633D4119,32'h793501C9,32'h7AD80F0B,
        32'h4E5DF04E,32'h97AF6884,32'hAE3A9745,32'hA3ACF48B,32'h16398A10,32'hDE8346C3,
        32'h42C20606,32'h03EAB4B1,32'h8798FDCC,32'h9CE4FC22,32'h81B5DD3D,32'h563431BE,
        32'h2D799349,32'hF2036C92,32'hB7E97B3C,32'h71E559C5,32'h5960C4BD,32'h295B63F8,
        32'hBA5F0B57,32'hE5B93DCE,32'h6A4ACC90,32'h89EC6516,32'h4180D566,32'h40263300,
        32'h9DE738CB,32'h4F2B3746,32'h9F66DF9E,32'hC0C8CEA7
    };

endpackage

[rtl/core/csht_key.sv]
module csht_key
    import csht_pkg::*;
#(
    parameter int KEY_BYTES = KEY_BYTES_DEF,
    localparam int KAW = $clog2(KEY_BYTES),
    localparam int KLW = $clog2(KEY_BYTES + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  logic           i_last,
    input  logic [7:0]     i_byte,
    input  logic [KAW-1:0] i_rd_idx,
    output logic [7:0]     o_rd_char,
    output logic [KLW-1:0] o_cur_len,
    output logic [KLW-1:0] o_next_len,
    output t_key_info      o_next
);

    logic [31:0]    r_hash;
    logic [KLW-1:0] r_len;
    logic           r_ovf;
    logic [7:0]     r_buf [KEY_BYTES];
    logic           first;
    logic           room;

    // Hash, length and overflow after the byte now offered.
    always_comb begin
        first = (r_len == '0) && !r_ovf;
        room  = r_len < KLW'(KEY_BYTES);
        if (first) begin
            o_next.hash = {24'd0, i_byte};
        end else begin
            o_next.hash = r_hash + MIX_TABLE[r_hash[31:24] ^ i_byte];
        end
        o_next.ovf = r_ovf || !room;
        o_next_len = room ? r_len + 1'b1 : r_len;
    end

    // Key state returns to empty after every last byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_len  <= '0;
            r_ovf  <= 1'b0;
        end else if (i_take) begin
            if (i_last) begin
                r_hash <= '0;
                r_len  <= '0;
                r_ovf  <= 1'b0;
            end else begin
                r_hash <= o_next.hash;
                r_len  <= o_next_len;
                r_ovf  <= o_next.ovf;
            end
        end
    end

    // Key bytes are kept for comparison during a chain walk.
    always_ff @(posedge i_clk) begin
        if (i_take && room) begin
            r_buf[r_len[KAW-1:0]] <= i_byte;
        end
    end

    assign o_rd_char = r_buf[i_rd_idx];
    assign o_cur_len = r_len;

endmodule

[rtl/core/chained_string_hash_table_top.sv]
// Keyed store with chained buckets. A key enters one byte per word on the
// slave stream; tlast marks its final byte, and tuser on that word carries
// the operation (put, get or clear) and tdata the payload for a put. After
// the last byte is taken, a put passes through the dispatch and head states,
// and a get then walks the chain: each entry visited is passed over when its
// key length differs and is otherwise compared byte by byte, all through one
// compare unit that reads the entry memories one byte per cycle. A clear
// sweeps the bucket heads one per cycle, and the same sweep runs after reset
// before the first byte is taken. The input is not ready while a last byte is
// worked on; a finished result waits in the output register.
`include "chained_string_hash_table_top_macros.svh"

module chained_string_hash_table_top
    import csht_pkg::*;
#(
    parameter int BUCKETS   = BUCKETS_DEF,
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int KEY_BYTES = KEY_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration: bucket_mask.
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MASK_W-1:0] i_cfg_data,
    // Key stream.
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [39:0]       i_s_tdata,   // key_byte [7:0], payload [39:8]
    input  logic [1:0]        i_s_tuser,   // op [1:0]
    input  logic              i_s_tlast,
    // Result stream.
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [55:0]       o_m_tdata,   // entry_index [9:0], found_payload [41:10],
                                           // element_count [52:42], zero [55:53]
    output logic [2:0]        o_m_tuser    // status [2:0]
);

    localparam int BW  = $clog2(BUCKETS);
    localparam int IW  = $clog2(ENTRIES);
    localparam int LW  = $clog2(ENTRIES + 1);
    localparam int KAW = $clog2(KEY_BYTES);
    localparam int KLW = $clog2(KEY_BYTES + 1);
    localparam int CHAR_DEPTH = ENTRIES << KAW;
    localparam logic [LW-1:0] NONE = LW'(ENTRIES);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_HEAD, S_CMP, S_OUT
    } t_state;

    // Memories.
    logic [LW-1:0]           m_heads [BUCKETS];
    logic [7:0]              m_chars [CHAR_DEPTH];
    logic [KLW-1:0]          m_len   [ENTRIES];
    logic [LW-1:0]           m_next  [ENTRIES];
    logic [PAYLOAD_BITS-1:0] m_data  [ENTRIES];

    t_state                  r_state;
    logic [MASK_W-1:0]       r_mask;
    logic [LW-1:0]           r_count;
    logic [BW-1:0]           r_sweep;
    logic                    r_clr_report;
    logic [BW-1:0]           r_bucket;
    logic [1:0]              r_op;
    logic                    r_kovf;
    logic [KLW-1:0]          r_klen;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [LW-1:0]           r_e;
    logic [KLW-1:0]          r_i;
    logic [LW-1:0]           r_head_q;
    logic [7:0]              r_char_q;
    logic [KLW-1:0]          r_len_q;
    logic [LW-1:0]           r_next_q;
    logic [PAYLOAD_BITS-1:0] r_data_q;
    logic [2:0]              r_res_status;
    logic [INDEX_W-1:0]      r_res_idx;
    logic [PAYLOAD_BITS-1:0] r_res_pay;
    logic                    r_ovalid;
    logic [2:0]              r_ostatus;
    logic [INDEX_W-1:0]      r_oidx;
    logic [PAYLOAD_BITS-1:0] r_opay;
    logic [COUNT_W-1:0]      r_ocount;

    logic [LW-1:0]           n_e;
    logic [KLW-1:0]          n_i;

    logic                    take;
    logic [7:0]              in_byte;
    logic [KLW-1:0]          cur_len;
    logic [KLW-1:0]          next_len;
    t_key_info               next_info;
    logic [7:0]              key_char;
    logic [31:0]             mask_wide;
    logic                    len_ok;
    logic                    at_end;
    logic                    cmp_match;
    logic                    cmp_step;
    logic                    cmp_miss;
    logic                    heads_we;
    logic [BW-1:0]           heads_wa;
    logic [LW-1:0]           heads_wd;
    logic                    chars_we;

    assign in_byte     = i_s_tdata[7:0];
    assign o_s_tready  = (r_state == S_IDLE);
    assign take        = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign mask_wide   = {{(32 - MASK_W){1'b0}}, r_mask};

    // Key collection and hashing.
    csht_key #(
        .KEY_BYTES (KEY_BYTES)
    ) u_key (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_last     (i_s_tlast),
        .i_byte     (in_byte),
        .i_rd_idx   (r_i[KAW-1:0]),
        .o_rd_char  (key_char),
        .o_cur_len  (cur_len),
        .o_next_len (next_len),
        .o_next     (next_info)
    );

    // Compare unit decisions and the next entry address to read.
    always_comb begin
        len_ok    = (r_len_q == r_klen);
        at_end    = (r_i == r_klen);
        cmp_match = len_ok && at_end;
        cmp_step  = len_ok && !at_end && (r_char_q == key_char);
        cmp_miss  = !cmp_match && !cmp_step;
        n_e = r_e;
        n_i = r_i;
        case (r_state)
            S_HEAD: begin
                n_e = r_head_q;
                n_i = '0;
            end
            S_CMP: begin
                if (cmp_step) begin
                    n_i = r_i + 1'b1;
                end else if (cmp_miss) begin
                    n_e = r_next_q;
                    n_i = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Bucket head write port: the clearing sweep or the link of a put.
    always_comb begin
        heads_we = 1'b0;
        heads_wa = r_sweep;
        heads_wd = NONE;
        if (r_state == S_CLEAR) begin
            heads_we = 1'b1;
        end else if (r_state == S_HEAD && r_op == OP_PUT) begin
            heads_we = 1'b1;
            heads_wa = r_bucket;
            heads_wd = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (heads_we) begin
            m_heads[heads_wa] <= heads_wd;
        end
        r_head_q <= m_heads[r_bucket];
    end

    // Key bytes go straight into the next free entry as they arrive.
    assign chars_we = take && (r_count < NONE) && (cur_len < KLW'(KEY_BYTES));

    always_ff @(posedge i_clk) begin
        if (chars_we) begin
            m_chars[{r_count[IW-1:0], cur_len[KAW-1:0]}] <= in_byte;
        end
        r_char_q <= m_chars[{n_e[IW-1:0], n_i[KAW-1:0]}];
    end

    // Entry length, payload and link; a full table keeps every entry as it is.
    always_ff @(posedge i_clk) begin
        if (r_state == S_DISPATCH && r_op == OP_PUT && r_count < NONE) begin
            m_len[r_count[IW-1:0]]  <= r_klen;
            m_data[r_count[IW-1:0]] <= r_pay;
        end
        if (r_state == S_HEAD && r_op == OP_PUT) begin
            m_next[r_count[IW-1:0]] <= r_head_q;
        end
        r_len_q  <= m_len[n_e[IW-1:0]];
        r_next_q <= m_next[n_e[IW-1:0]];
        r_data_q <= m_data[n_e[IW-1:0]];
    end

    // Sequencer and result registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_mask       <= MASK_RESET;
            r_count      <= '0;
            r_sweep      <= '0;
            r_clr_report <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mask <= i_cfg_data;
            end
            if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            r_e <= n_e;
            r_i <= n_i;
            case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == BW'(BUCKETS - 1)) begin
                        if (r_clr_report) begin
                            r_res_status <= ST_CLEARED;
                            r_res_idx    <= '0;
                            r_res_pay    <= '0;
                            r_state      <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (take && i_s_tlast) begin
                        r_op     <= i_s_tuser;
                        r_kovf   <= next_info.ovf;
                        r_klen   <= next_len;
                        r_pay    <= i_s_tdata[39:8];
                        r_bucket <= BW'(next_info.hash & mask_wide);
                        r_state  <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    r_res_idx <= '0;
                    r_res_pay <= '0;
                    case (r_op)
                        OP_CLEAR: begin
                            r_count      <= '0;
                            r_sweep      <= '0;
                            r_clr_report <= 1'b1;
                            r_state      <= S_CLEAR;
                        end
                        OP_PUT, OP_GET: begin
                            if (r_kovf) begin
                                r_res_status <= ST_TOO_LONG;
                                r_state      <= S_OUT;
                            end else if (r_op == OP_PUT && r_count >= NONE) begin
                                r_res_status <= ST_FULL;
                                r_state      <= S_OUT;
                            end else begin
                                r_state <= S_HEAD;
                            end
                        end
                        default: begin
                            // Undefined operation: the key is dropped quietly.
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_HEAD: begin
                    if (r_op == OP_PUT) begin
                        r_count      <= r_count + 1'b1;
                        r_res_status <= ST_INSERTED;
                        r_res_idx    <= INDEX_W'(r_count);
                        r_state      <= S_OUT;
                    end else if (r_head_q == NONE) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_OUT;
                    end else begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (cmp_match) begin
                        r_res_status <= ST_FOUND;
                        r_res_idx    <= INDEX_W'(r_e);
                        r_res_pay    <= r_data_q;
                        r_state      <= S_OUT;
                    end else if (cmp_miss && r_next_q == NONE) begin
                        r_res_status <= ST_NOT_FOUND;
                        r_state      <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_m_tready) begin
                        r_ovalid  <= 1'b1;
                        r_ostatus <= r_res_status;
                        r_oidx    <= r_res_idx;
                        r_opay    <= r_res_pay;
                        r_ocount  <= COUNT_W'(r_count);
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ostatus;
    assign o_m_tdata  = {3'd0, r_ocount, r_opay, r_oidx};

    // The entry count never passes the capacity.
    `CSHT_ASSERT_NOW(a_count_bound, 1'b1, r_count <= NONE)
    // A last byte closes the input until its work is done.
    `CSHT_ASSERT_NEXT(a_last_blocks, take && i_s_tlast, !o_s_tready)
    // A successful put adds exactly one entry.
    `CSHT_ASSERT_NEXT(a_put_counts, r_state == S_HEAD && r_op == OP_PUT,
        r_count == $past(r_count) + 1'b1)
    // A found entry lies among the stored entries.
    `CSHT_ASSERT_NOW(a_found_stored, r_state == S_CMP && cmp_match, r_e < r_count)

endmodule
